### src/ple_pkg.sv
// Shared types and codes for the positional list engine.
`default_nettype none

package ple_pkg;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 6;
    localparam int LEN_W   = 7;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;

    // request codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // cell commands
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;

    localparam logic [LEN_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]        op;
        logic [LEN_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

`default_nettype wire

### src/ple_ifs.sv
// Handshake channels of the positional list engine: request, result, capacity write.
`default_nettype none

interface ple_req_if
    import ple_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   req_type;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] entry_value;

    modport source (output valid, req_type, position, entry_value, input ready);
    modport sink   (input valid, req_type, position, entry_value, output ready);
endinterface

interface ple_rsp_if
    import ple_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] entry_out;
    logic [LEN_W-1:0]  list_length;

    modport source (output valid, status, entry_out, list_length, input ready);
    modport sink   (input valid, status, entry_out, list_length, output ready);
endinterface

interface ple_cfg_if
    import ple_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### src/ple_cell.sv
// One list slot: holds an entry and shifts with its neighbors on insert or delete.
`default_nettype none

module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic [DATA_W-1:0] i_prev,
    input  wire logic [DATA_W-1:0] i_next,
    output logic      [DATA_W-1:0] o_q
);

    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        unique case (i_cmd.op)
            CELL_INS: begin
                if (IDX > int'(i_cmd.pos)) begin
                    n_q = i_prev;
                end else if (IDX == int'(i_cmd.pos)) begin
                    n_q = i_cmd.value;
                end
            end
            CELL_DEL: begin
                if (IDX >= int'(i_cmd.pos)) begin
                    n_q = i_next;
                end
            end
            default: n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

### src/positional_list_engine.sv
// Top level of the positional list engine: control, cell row and result register.
`default_nettype none

// Ordered list of up to list_capacity 32-bit entries kept in a row of
// STORE_DEPTH cells. On insert or delete the cells from the request position
// up shift up or down by one slot, and the result of every request (insert,
// get, delete, clear) is registered at the same edge, so a new item is taken
// every cycle while the result register is empty or being drained. Nothing is
// taken on any channel while reset is held. The capacity register is written
// through its own channel, ready whenever reset is released, and is clamped
// to STORE_DEPTH, at most 127. No clearing pass after reset; the list starts empty.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int STORE_DEPTH = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ple_req_if.sink   i_req,
    ple_rsp_if.source o_rsp,
    ple_cfg_if.sink   i_cfg
);

    localparam logic [LEN_W-1:0] DEPTH_CAP =
        (STORE_DEPTH > 127) ? 7'd127 : LEN_W'(STORE_DEPTH);

    logic [LEN_W-1:0]  r_cap;
    logic [LEN_W-1:0]  r_count;
    logic [LEN_W-1:0]  n_count;
    logic              r_out_valid;
    logic [ST_W-1:0]   r_status;
    logic [ST_W-1:0]   n_status;
    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    logic [LEN_W-1:0]  cap_eff;
    logic [LEN_W-1:0]  pos_ext;
    logic [DATA_W-1:0] rd_data;
    logic              accept;
    t_cell_cmd         cmd;
    logic [DATA_W-1:0] w_q [STORE_DEPTH];

    assign i_cfg.ready = i_rst_n;
    assign i_req.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    assign cap_eff = (r_cap > DEPTH_CAP) ? DEPTH_CAP : r_cap;
    assign pos_ext = {1'b0, i_req.position};

    // one-hot select over the row
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (i == int'(i_req.position)) begin
                rd_data = rd_data | w_q[i];
            end
        end
    end

    always_comb begin
        n_status  = ST_OK;
        n_entry   = '0;
        n_count   = r_count;
        cmd.op    = CELL_HOLD;
        cmd.pos   = pos_ext;
        cmd.value = i_req.entry_value;
        unique case (i_req.req_type)
            OP_INSERT: begin
                if (pos_ext >= cap_eff) begin
                    n_status = ST_RANGE;
                end else if (r_count >= cap_eff) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.op  = CELL_INS;
                    cmd.pos = (pos_ext > r_count) ? r_count : pos_ext;
                    n_count = r_count + 7'd1;
                end
            end
            OP_GET, OP_DELETE: begin
                if (pos_ext >= r_count || int'(i_req.position) >= STORE_DEPTH) begin
                    n_status = ST_RANGE;
                end else begin
                    n_entry = rd_data;
                    if (i_req.req_type == OP_DELETE) begin
                        cmd.op  = CELL_DEL;
                        n_count = r_count - 7'd1;
                    end
                end
            end
            OP_CLEAR: n_count = '0;
            default:  n_count = r_count;
        endcase
        if (!accept) begin
            cmd.op = CELL_HOLD;
        end
    end

    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] prev_q;
        logic [DATA_W-1:0] next_q;
        if (g == 0) begin : g_first
            assign prev_q = i_req.entry_value;
        end else begin : g_mid
            assign prev_q = w_q[g-1];
        end
        if (g == STORE_DEPTH - 1) begin : g_last
            assign next_q = w_q[g];
        end else begin : g_body
            assign next_q = w_q[g+1];
        end
        ple_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (cmd),
            .i_prev (prev_q),
            .i_next (next_q),
            .o_q    (w_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_cap <= i_cfg.data;
            end
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_entry  <= n_entry;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_out   = r_entry;
    assign o_rsp.list_length = r_count;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CAP)
        else $error("list length beyond store depth");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.req_type == OP_CLEAR |=> r_out_valid && r_count == '0)
        else $error("clear left entries");

    a_reject_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_status == ST_OK || r_count == $past(r_count)))
        else $error("rejected item changed length");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_OK |-> r_entry == '0)
        else $error("rejected item returned data");
`endif

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the positional list engine: directed table, then random phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 78;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] entry;
        logic [LEN_W-1:0]  length;
    } list_result_t;

    typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_kind_e;
    typedef enum logic [1:0] {MIX_GROW, MIX_EVEN, MIX_SHRINK} op_mix_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        logic              typed;
        list_result_t      want;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ple_req_if request_ch ();
    ple_rsp_if result_ch ();
    ple_cfg_if capacity_ch ();

    positional_list_engine #(
        .STORE_DEPTH(LIST_DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (request_ch),
        .o_rsp  (result_ch),
        .i_cfg  (capacity_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the list
    logic [DATA_W-1:0] list_mem [LIST_DEPTH];
    int unsigned       list_len = 0;
    logic [LEN_W-1:0]  cap_setting = CAP_RESET;

    list_result_t expected_results [$];
    stim_row_t    directed_rows [$];

    bit steady_flow = 1'b0;
    int failures = 0;
    int results_checked = 0;
    int cap_writes = 0;
    int op_count [4] = '{0, 0, 0, 0};
    int range_rejects = 0;
    int full_rejects = 0;
    int unsigned peak_len = 0;
    int quiet_cycles = 0;

    function automatic list_result_t apply_request(input logic [OP_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DATA_W-1:0] val);
        list_result_t res;
        int unsigned limit;
        int unsigned slot;
        limit = (cap_setting > LIST_DEPTH) ? LIST_DEPTH : cap_setting;
        slot = pos;
        res = '0;
        res.status = ST_OK;
        case (op)
            OP_INSERT: begin
                // position is tested against the capacity before fullness
                if (slot >= limit) begin
                    res.status = ST_RANGE;
                end else if (list_len >= limit) begin
                    res.status = ST_FULL;
                end else begin
                    if (slot > list_len) slot = list_len;
                    for (int i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
                    list_mem[slot] = val;
                    list_len++;
                end
            end
            OP_GET, OP_DELETE: begin
                if (slot >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.entry = list_mem[slot];
                    if (op == OP_DELETE) begin
                        for (int i = slot + 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
                        list_len--;
                    end
                end
            end
            default: list_len = 0;
        endcase
        res.length = LEN_W'(list_len);
        return res;
    endfunction

    function automatic void report_failure(input string msg);
        failures++;
        if (failures <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function automatic void add_row(input row_kind_e kind, input logic [OP_W-1:0] op,
                                    input logic [POS_W-1:0] pos,
                                    input logic [DATA_W-1:0] val, input logic typed,
                                    input logic [ST_W-1:0] st,
                                    input logic [DATA_W-1:0] ent,
                                    input logic [LEN_W-1:0] len);
        stim_row_t row;
        row.kind = kind;
        row.op = op;
        row.pos = pos;
        row.val = val;
        row.typed = typed;
        row.want.status = st;
        row.want.entry = ent;
        row.want.length = len;
        directed_rows.push_back(row);
    endfunction

    task automatic issue_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                 input logic [DATA_W-1:0] val, input logic typed,
                                 input list_result_t want);
        list_result_t pred;
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        request_ch.valid       <= 1'b1;
        request_ch.req_type    <= op;
        request_ch.position    <= pos;
        request_ch.entry_value <= val;
        do @(posedge i_clk); while (request_ch.ready !== 1'b1);
        pred = apply_request(op, pos, val);
        expected_results.push_back(typed ? want : pred);
        op_count[op]++;
        if (pred.status == ST_RANGE) range_rejects++;
        if (pred.status == ST_FULL) full_rejects++;
        if (list_len > peak_len) peak_len = list_len;
    endtask

    // only written once every outstanding result has come back
    task automatic write_capacity(input logic [LEN_W-1:0] cap);
        request_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        capacity_ch.valid <= 1'b1;
        capacity_ch.data  <= cap;
        do @(posedge i_clk); while (capacity_ch.ready !== 1'b1);
        capacity_ch.valid <= 1'b0;
        cap_setting = cap;
        cap_writes++;
    endtask

    initial begin : result_sink
        list_result_t want;
        int unsigned stall;
        result_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (result_ch.valid !== 1'b1);
            if (expected_results.size() == 0) begin
                report_failure($sformatf("unexpected result: status %0d entry %h length %0d",
                               result_ch.status, result_ch.entry_out, result_ch.list_length));
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (result_ch.status !== want.status || result_ch.entry_out !== want.entry ||
                    result_ch.list_length !== want.length) begin
                    report_failure($sformatf(
                        "result %0d: expected status %0d entry %h length %0d, got %0d %h %0d",
                        results_checked, want.status, want.entry, want.length,
                        result_ch.status, result_ch.entry_out, result_ch.list_length));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (capacity_ch.valid && capacity_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [LEN_W-1:0] phase_cap [PHASES];
        op_mix_e          phase_mix [PHASES];
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        int unsigned roll;
        int unsigned ins_w;
        int unsigned get_w;
        int unsigned del_w;

        i_rst_n                <= 1'b0;
        request_ch.valid       <= 1'b0;
        request_ch.req_type    <= OP_CLEAR;
        request_ch.position    <= '0;
        request_ch.entry_value <= '0;
        capacity_ch.valid      <= 1'b0;
        capacity_ch.data       <= '0;

        // empty list, then a few entries at both ends
        add_row(ROW_REQUEST, OP_GET,    6'd0,  32'h0,        1'b1, ST_RANGE, 32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_DELETE, 6'd63, 32'h0,        1'b1, ST_RANGE, 32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_INSERT, 6'd0,  32'hFFFFFFFF, 1'b1, ST_OK,    32'h0,        7'd1);
        add_row(ROW_REQUEST, OP_INSERT, 6'd63, 32'h0,        1'b1, ST_OK,    32'h0,        7'd2);
        add_row(ROW_REQUEST, OP_INSERT, 6'd0,  32'hA5A5A5A5, 1'b1, ST_OK,    32'h0,        7'd3);
        add_row(ROW_REQUEST, OP_GET,    6'd0,  32'h0,        1'b1, ST_OK,    32'hA5A5A5A5, 7'd3);
        add_row(ROW_REQUEST, OP_GET,    6'd2,  32'h0,        1'b1, ST_OK,    32'h0,        7'd3);
        add_row(ROW_REQUEST, OP_GET,    6'd3,  32'h0,        1'b1, ST_RANGE, 32'h0,        7'd3);
        add_row(ROW_REQUEST, OP_INSERT, 6'd1,  32'h5A5A5A5A, 1'b0, ST_OK,    32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_DELETE, 6'd1,  32'h0,        1'b0, ST_OK,    32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_DELETE, 6'd0,  32'h0,        1'b0, ST_OK,    32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_GET,    6'd0,  32'h0,        1'b0, ST_OK,    32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_CLEAR,  6'd63, 32'hFFFFFFFF, 1'b1, ST_OK,    32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_CLEAR,  6'd0,  32'h0,        1'b1, ST_OK,    32'h0,        7'd0);
        // full list, and position checked before fullness
        add_row(ROW_CAPACITY, OP_CLEAR, 6'd0,  32'd2,        1'b0, ST_OK,    32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_INSERT, 6'd0,  32'd1,        1'b1, ST_OK,    32'h0,        7'd1);
        add_row(ROW_REQUEST, OP_INSERT, 6'd1,  32'd2,        1'b1, ST_OK,    32'h0,        7'd2);
        add_row(ROW_REQUEST, OP_INSERT, 6'd0,  32'd3,        1'b1, ST_FULL,  32'h0,        7'd2);
        add_row(ROW_REQUEST, OP_INSERT, 6'd2,  32'd3,        1'b1, ST_RANGE, 32'h0,        7'd2);
        // capacity lowered below the length: entries stay readable
        add_row(ROW_CAPACITY, OP_CLEAR, 6'd0,  32'd1,        1'b0, ST_OK,    32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_GET,    6'd1,  32'h0,        1'b0, ST_OK,    32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_INSERT, 6'd0,  32'd4,        1'b1, ST_FULL,  32'h0,        7'd2);
        add_row(ROW_REQUEST, OP_DELETE, 6'd0,  32'h0,        1'b0, ST_OK,    32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_INSERT, 6'd0,  32'd5,        1'b1, ST_FULL,  32'h0,        7'd1);
        // zero capacity rejects on position; oversize capacity clamps to the depth
        add_row(ROW_CAPACITY, OP_CLEAR, 6'd0,  32'd0,        1'b0, ST_OK,    32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_INSERT, 6'd0,  32'd6,        1'b1, ST_RANGE, 32'h0,        7'd1);
        add_row(ROW_CAPACITY, OP_CLEAR, 6'd0,  32'd127,      1'b0, ST_OK,    32'h0,        7'd0);
        add_row(ROW_REQUEST, OP_INSERT, 6'd63, 32'd7,        1'b1, ST_OK,    32'h0,        7'd2);
        add_row(ROW_REQUEST, OP_CLEAR,  6'd0,  32'h0,        1'b1, ST_OK,    32'h0,        7'd0);

        phase_cap = '{7'd64, 7'd64, 7'd5, 7'd127, 7'd1, 7'd0, 7'd65,
                      LEN_W'($urandom_range(0, 127)), LEN_W'($urandom_range(0, 127)), 7'd64};
        phase_mix = '{MIX_GROW, MIX_GROW, MIX_SHRINK, MIX_SHRINK, MIX_EVEN, MIX_EVEN,
                      MIX_GROW, MIX_GROW, MIX_SHRINK, MIX_EVEN};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CAPACITY) begin
                write_capacity(directed_rows[i].val[LEN_W-1:0]);
            end else begin
                issue_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                              directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int k = 0; k < PHASES; k++) begin
            write_capacity(phase_cap[k]);
            steady_flow = (k == 3 || k == 7);
            case (phase_mix[k])
                MIX_GROW:   begin ins_w = 72; get_w = 15; del_w = 12; end
                MIX_SHRINK: begin ins_w = 20; get_w = 25; del_w = 53; end
                default:    begin ins_w = 40; get_w = 30; del_w = 27; end
            endcase
            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < ins_w) op = OP_INSERT;
                else if (roll < ins_w + get_w) op = OP_GET;
                else if (roll < ins_w + get_w + del_w) op = OP_DELETE;
                else op = OP_CLEAR;
                // mostly positions inside the list, the rest anywhere
                if (op == OP_INSERT && $urandom_range(0, 99) < 75) begin
                    pos = POS_W'($urandom_range(0, (list_len > 63) ? 63 : list_len));
                end else if (op != OP_INSERT && list_len > 0 && $urandom_range(0, 99) < 85) begin
                    pos = POS_W'($urandom_range(0, list_len - 1));
                end else begin
                    pos = POS_W'($urandom_range(0, 63));
                end
                case ($urandom_range(0, 19))
                    0:       val = '0;
                    1:       val = '1;
                    default: val = $urandom;
                endcase
                issue_request(op, pos, val, 1'b0, '0);
            end
        end

        request_ch.valid <= 1'b0;
        steady_flow = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Checked %0d results: %0d inserts, %0d gets, %0d deletes, %0d clears",
                 results_checked, op_count[OP_INSERT], op_count[OP_GET], op_count[OP_DELETE],
                 op_count[OP_CLEAR]);
        $display("%0d capacity writes, longest list %0d, %0d range and %0d full rejects",
                 cap_writes, peak_len, range_rejects, full_rejects);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d failures", failures);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
src/ple_pkg.sv
src/ple_ifs.sv
src/ple_cell.sv
src/positional_list_engine.sv
verif/tb.sv
